[design/set_assoc_lru_tag_tracker_top_defines.svh]
// Assertion macros used by the checker of the tag tracker.
`ifndef SET_ASSOC_LRU_TAG_TRACKER_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_TAG_TRACKER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define SALT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SALT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/salt_pkg.sv]
// Package with the types, codes and constants of the tag tracker.
`default_nettype none

package salt_pkg;

  localparam int ADDR_W            = 13;
  localparam int TAG_W             = ADDR_W;
  localparam int SIDX_W            = 8;
  localparam int STATUS_W          = 2;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 5;
  localparam int BSL_W             = 3;
  localparam int RLOG_W            = 4;
  localparam int WAYS_W            = 5;
  localparam int DEF_MAX_ROWS_LOG2 = 8;
  localparam int DEF_MAX_WAYS      = 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOAD_HIT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STORE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS_LOG2   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS            = 2'd2;

  localparam logic [BSL_W-1:0]  BSL_RST  = 3'd1;
  localparam logic [RLOG_W-1:0] RLOG_RST = 4'd1;
  localparam logic [WAYS_W-1:0] WAYS_RST = 5'd1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] word_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   set_index;
  } out_item_t;

endpackage

`default_nettype wire

[design/salt_row_update.sv]
// Tag compare across the ways of one set and the LRU reorder of that set.
`default_nettype none

module salt_row_update import salt_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  localparam int CNT_W = $clog2(MAX_WAYS + 1),
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0][TAG_W-1:0] old_tags,
  input  logic [MAX_WAYS-1:0]            old_valid,
  input  logic [TAG_W-1:0]               tag,
  input  logic [CNT_W-1:0]               num_ways,
  output logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags,
  output logic [MAX_WAYS-1:0]            new_valid,
  output logic                           hit
);

  logic [MAX_WAYS-1:0] match;
  logic [WAY_W-1:0]    pos;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = old_valid[w] && (old_tags[w] == tag) && (CNT_W'(w) < num_ways);
    end
  end

  // The first matching way wins; on a miss the last way in use is the victim.
  always_comb begin
    pos = WAY_W'(num_ways - CNT_W'(1));
    hit = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        pos = WAY_W'(w);
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    new_tags[0]  = tag;
    new_valid[0] = 1'b1;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) <= pos) begin
        new_tags[w]  = old_tags[w-1];
        new_valid[w] = old_valid[w-1];
      end else begin
        new_tags[w]  = old_tags[w];
        new_valid[w] = old_valid[w];
      end
    end
  end

endmodule

`default_nettype wire

[design/set_assoc_lru_tag_tracker_top.sv]
// Top level of the set-associative tag tracker with LRU replacement.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_item_t (kind, word_address)
//   out_     output     out_valid/out_stall out_item_t (status, set_index)
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// Each item first reads its set's row from the tag memory, whose read data
// is registered, and then is compared and its row written back.
// A single item is in flight, so a read never meets a pending write.
// Reset clears one valid flag per row at once; there is no clearing pass.
// The result sits in an output register; the lookup waits while it is held.
`default_nettype none

module set_assoc_lru_tag_tracker_top import salt_pkg::*; #(
  parameter int MAX_ROWS_LOG2 = DEF_MAX_ROWS_LOG2,
  parameter int MAX_WAYS      = DEF_MAX_WAYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SET_W = (MAX_ROWS_LOG2 > 0) ? MAX_ROWS_LOG2 : 1;
  localparam int ROWS  = 1 << MAX_ROWS_LOG2;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * (TAG_W + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic [BSL_W-1:0]  bsl_r;
  logic [RLOG_W-1:0] rlog_r;
  logic [WAYS_W-1:0] ways_r;

  logic state_r, state_nxt;

  logic                req_kind_r;
  logic [SET_W-1:0]    req_set_r;
  logic [SIDX_W-1:0]   req_sidx_r;
  logic [TAG_W-1:0]    req_tag_r;

  logic [ROW_W-1:0] row_mem_r [ROWS];
  logic [ROW_W-1:0] rd_row_r;
  logic             rd_rowv_r;
  logic [ROWS-1:0]  row_valid_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic                 in_acc;
  logic                 done;
  logic [RLOG_W-1:0]    rl;
  logic [WAYS_W-1:0]    nw;
  logic [ADDR_W-1:0]    bid;
  logic [ADDR_W-1:0]    set_mask;
  logic [ADDR_W-1:0]    set_full;
  logic [SET_W-1:0]     acc_set;

  logic [MAX_WAYS-1:0][TAG_W-1:0] old_tags, new_tags;
  logic [MAX_WAYS-1:0]            old_valid, new_valid;
  logic                           hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign done      = (state_r == S_LOOK) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rl = (rlog_r > RLOG_W'(MAX_ROWS_LOG2)) ? RLOG_W'(MAX_ROWS_LOG2) : rlog_r;
    if (ways_r == '0) begin
      nw = WAYS_W'(1);
    end else if (ways_r > WAYS_W'(MAX_WAYS)) begin
      nw = WAYS_W'(MAX_WAYS);
    end else begin
      nw = ways_r;
    end
    bid      = in_data.word_address >> bsl_r;
    set_mask = (ADDR_W'(1) << rl) - ADDR_W'(1);
    set_full = bid & set_mask;
    acc_set  = set_full[SET_W-1:0];
  end

  assign old_tags  = rd_row_r[ROW_W-1:MAX_WAYS];
  assign old_valid = rd_rowv_r ? rd_row_r[MAX_WAYS-1:0] : '0;

  salt_row_update #(
    .MAX_WAYS(MAX_WAYS)
  ) u_row_update (
    .old_tags (old_tags),
    .old_valid(old_valid),
    .tag      (req_tag_r),
    .num_ways (CNT_W'(nw)),
    .new_tags (new_tags),
    .new_valid(new_valid),
    .hit      (hit)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        if (done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bsl_r   <= BSL_RST;
      rlog_r  <= RLOG_RST;
      ways_r  <= WAYS_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_SIZE_LOG2: bsl_r  <= cfg_wdata[BSL_W-1:0];
          CFG_NUM_ROWS_LOG2:   rlog_r <= cfg_wdata[RLOG_W-1:0];
          CFG_WAYS:            ways_r <= cfg_wdata[WAYS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Any register write flushes the cache by clearing every row flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cfg_we && (cfg_index == CFG_BLOCK_SIZE_LOG2 ||
                            cfg_index == CFG_NUM_ROWS_LOG2 ||
                            cfg_index == CFG_WAYS)) begin
      row_valid_r <= '0;
    end else if (done) begin
      row_valid_r[req_set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r   <= row_mem_r[acc_set];
      rd_rowv_r  <= row_valid_r[acc_set];
      req_kind_r <= in_data.kind;
      req_set_r  <= acc_set;
      req_sidx_r <= set_full[SIDX_W-1:0];
      req_tag_r  <= bid >> rl;
    end
    if (done) begin
      row_mem_r[req_set_r] <= {new_tags, new_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (req_kind_r == KIND_STORE) begin
        out_data_r.status <= ST_STORE;
      end else if (hit) begin
        out_data_r.status <= ST_LOAD_HIT;
      end else begin
        out_data_r.status <= ST_LOAD_MISS;
      end
      out_data_r.set_index <= req_sidx_r;
    end
  end

endmodule

`default_nettype wire

[design/salt_checker.sv]
// Port-level checker for the tag tracker and its bind to the top level.
`default_nettype none
`include "set_assoc_lru_tag_tracker_top_defines.svh"

module salt_checker import salt_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_item_t             out_data
);

  logic in_acc;
  logic acc_q_r;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_q_r <= 1'b0;
    end else begin
      acc_q_r <= in_acc;
    end
  end

  `SALT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "Stalled result changed or vanished.")
  `SALT_ASSERT(a_one_in_flight, clk, rst_n, in_acc |=> in_stall, "A second item was taken while one was in lookup.")
  `SALT_ASSERT(a_rise_after_acc, clk, rst_n, $rose(out_valid) |-> $past(acc_q_r), "A result appeared without an item two cycles before.")
  `SALT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "A result is shown right after reset.")

endmodule

bind set_assoc_lru_tag_tracker_top salt_checker u_salt_checker (.*);

`default_nettype wire
